// ===== rtl/smd_pkg.sv =====
package smd_pkg;

  // Sample width on the ports and in the buffer.
  localparam int unsigned SAMPLE_W = 16;
  // Width of the image count register and of every count that it bounds.
  localparam int unsigned COUNT_W = 7;
  // Running sum of up to 127 samples.
  localparam int unsigned SUM_W = SAMPLE_W + COUNT_W;
  // One squared deviation.
  localparam int unsigned SQ_W = 2 * SAMPLE_W;
  // Sum of up to 127 squared deviations; also the divider's dividend width.
  localparam int unsigned ACC_W = SQ_W + COUNT_W;
  // Width of the shared compare and subtract stage.
  localparam int unsigned CMP_W = SAMPLE_W + 4;
  // Step counter of the shared unit.
  localparam int unsigned STEP_W = 6;
  localparam int unsigned DIV_STEPS = ACC_W;
  localparam int unsigned ROOT_STEPS = SQ_W / 2;

  // Configuration port.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_IMAGE_COUNT = 1'b0;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_PASS,
    ST_MSD_GO,
    ST_MSD_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT
  } seq_state_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

endpackage

// ===== rtl/stack_mean_and_deviation.sv =====
// Per-pixel mean and standard deviation over a stack of images. Each sample
// (one word on start_i while busy_o is low) is the current pixel's amplitude in
// the next image; it is stored and summed when accepted, so the samples of a
// pixel enter back to back. The word for the last image (image_count samples,
// where zero counts as one and values above MAX_IMAGES count as MAX_IMAGES)
// raises busy_o while the pixel is worked out: one shared iterative unit first
// divides the sum by n for the mean, then the sample buffer is read once more
// and the squared deviations from that mean are summed, the sum is divided by
// n and its floor square root is taken. The result is shown on avg_amplitude_o
// and amplitude_deviation_o for exactly one cycle with result_valid_o, in the
// cycle in which busy_o falls, so busy_o is already low in that cycle. The
// receiver cannot stall the block, so the result must be taken in that cycle.
// Writing image_count discards a partly received pixel; write it only while
// busy_o is low. The sample buffer needs no clearing after reset: only entries
// written for the current pixel are read.
module stack_mean_and_deviation #(
  parameter int unsigned MAX_IMAGES     = 64,
  parameter int unsigned AMPLITUDE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [smd_pkg::SAMPLE_W-1:0]  amplitude_i,

  output logic                          result_valid_o,
  output logic [smd_pkg::SAMPLE_W-1:0]  avg_amplitude_o,
  output logic [smd_pkg::SAMPLE_W-1:0]  amplitude_deviation_o,

  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [smd_pkg::ADDR_W-1:0]    paddr_i,
  input  logic [smd_pkg::DATA_W-1:0]    pwdata_i,
  output logic [smd_pkg::DATA_W-1:0]    prdata_o,
  output logic                          pready_o
);

  localparam int unsigned IDX_W = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;

  // Only the low AMPLITUDE_BITS bits of a sample take part.
  localparam logic [smd_pkg::SAMPLE_W-1:0] AMP_MASK =
      (AMPLITUDE_BITS >= smd_pkg::SAMPLE_W) ? {smd_pkg::SAMPLE_W{1'b1}} :
      smd_pkg::SAMPLE_W'((1 << AMPLITUDE_BITS) - 1);

  // Configuration register.
  logic [smd_pkg::COUNT_W-1:0] image_count_q;
  logic                        cfg_write;
  logic                        cfg_hit;

  assign pready_o  = 1'b1;
  assign cfg_hit   = (paddr_i[2] == smd_pkg::REG_IMAGE_COUNT);
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o  = cfg_hit ? smd_pkg::DATA_W'(image_count_q) : '0;

  // Number of samples per pixel after the zero and ceiling rules.
  logic [smd_pkg::COUNT_W-1:0] n_eff;

  always_comb begin
    if (image_count_q == '0) begin
      n_eff = smd_pkg::COUNT_W'(1);
    end else if (int'(image_count_q) > int'(MAX_IMAGES)) begin
      n_eff = smd_pkg::COUNT_W'(MAX_IMAGES);
    end else begin
      n_eff = image_count_q;
    end
  end

  // Sequencer and control state.
  smd_pkg::seq_state_e         state_q, state_d;
  logic [smd_pkg::COUNT_W-1:0] count_q, count_d;
  logic [smd_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [smd_pkg::COUNT_W-1:0] rd_idx_q, rd_idx_d;
  logic                        v1_q, v2_q, v3_q;
  logic                        valid_q, valid_d;

  // Datapath registers.
  logic [smd_pkg::SAMPLE_W-1:0] sample_buffer [MAX_IMAGES];
  logic [smd_pkg::SAMPLE_W-1:0] rd_data_q;
  logic [smd_pkg::SAMPLE_W-1:0] dev_q;
  logic [smd_pkg::SQ_W-1:0]     sq_q;
  logic [smd_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [smd_pkg::SAMPLE_W-1:0] mean_q, mean_d;
  logic [smd_pkg::SAMPLE_W-1:0] devout_q, devout_d;

  logic                         accept;
  logic [smd_pkg::SAMPLE_W-1:0] sample;
  logic                         rd_en;
  logic [IDX_W-1:0]             wr_addr, rd_addr;

  smd_pkg::arith_req_t          arith_req;
  smd_pkg::arith_rsp_t          arith_rsp;
  logic [smd_pkg::ACC_W-1:0]    arith_operand;
  logic [smd_pkg::ACC_W-1:0]    arith_result;

  assign busy_o  = (state_q != smd_pkg::ST_LOAD);
  assign accept  = start_i && !busy_o;
  assign sample  = amplitude_i & AMP_MASK;
  assign wr_addr = IDX_W'(count_q);
  assign rd_addr = IDX_W'(rd_idx_q);
  assign rd_en   = (state_q == smd_pkg::ST_PASS) && (rd_idx_q < n_eff);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    sum_d         = sum_q;
    rd_idx_d      = rd_idx_q;
    valid_d       = 1'b0;
    acc_d         = acc_q;
    mean_d        = mean_q;
    devout_d      = devout_q;
    arith_req     = '{start: 1'b0, op: smd_pkg::OP_DIV};
    arith_operand = smd_pkg::ACC_W'(sum_q);

    case (state_q)
      smd_pkg::ST_LOAD: begin
        if (cfg_write && cfg_hit) begin
          // A new image count discards any partly received pixel.
          count_d = '0;
          sum_d   = '0;
        end else if (accept) begin
          sum_d = sum_q + smd_pkg::SUM_W'(sample);
          if (smd_pkg::COUNT_W'(count_q + 1'b1) == n_eff) begin
            count_d = '0;
            state_d = smd_pkg::ST_MEAN_GO;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      smd_pkg::ST_MEAN_GO: begin
        arith_req     = '{start: 1'b1, op: smd_pkg::OP_DIV};
        arith_operand = smd_pkg::ACC_W'(sum_q);
        sum_d         = '0;
        state_d       = smd_pkg::ST_MEAN_WAIT;
      end
      smd_pkg::ST_MEAN_WAIT: begin
        if (arith_rsp.done) begin
          mean_d   = arith_result[smd_pkg::SAMPLE_W-1:0];
          rd_idx_d = '0;
          acc_d    = '0;
          state_d  = smd_pkg::ST_PASS;
        end
      end
      smd_pkg::ST_PASS: begin
        // Reads issue one per cycle; a squared term passes through rd_data_q,
        // dev_q and sq_q before it reaches the sum.
        if (rd_en) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (v3_q) begin
          acc_d = acc_q + smd_pkg::ACC_W'(sq_q);
        end
        if (!rd_en && !v1_q && !v2_q && !v3_q) begin
          state_d = smd_pkg::ST_MSD_GO;
        end
      end
      smd_pkg::ST_MSD_GO: begin
        arith_req     = '{start: 1'b1, op: smd_pkg::OP_DIV};
        arith_operand = acc_q;
        state_d       = smd_pkg::ST_MSD_WAIT;
      end
      smd_pkg::ST_MSD_WAIT: begin
        if (arith_rsp.done) begin
          state_d = smd_pkg::ST_SQRT_GO;
        end
      end
      smd_pkg::ST_SQRT_GO: begin
        // The unit still holds the mean squared deviation from the division.
        arith_req     = '{start: 1'b1, op: smd_pkg::OP_SQRT};
        arith_operand = arith_result;
        state_d       = smd_pkg::ST_SQRT_WAIT;
      end
      smd_pkg::ST_SQRT_WAIT: begin
        if (arith_rsp.done) begin
          devout_d = arith_result[smd_pkg::SAMPLE_W-1:0];
          valid_d  = 1'b1;
          state_d  = smd_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = smd_pkg::ST_LOAD;
      end
    endcase
  end

  smd_arith u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (arith_req),
    .operand_i (arith_operand),
    .divisor_i (n_eff),
    .rsp_o     (arith_rsp),
    .result_o  (arith_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= smd_pkg::ST_LOAD;
      count_q       <= '0;
      sum_q         <= '0;
      rd_idx_q      <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      valid_q       <= 1'b0;
      image_count_q <= smd_pkg::COUNT_W'(1);
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      rd_idx_q <= rd_idx_d;
      v1_q     <= rd_en;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      valid_q  <= valid_d;
      if (cfg_write && cfg_hit) begin
        image_count_q <= pwdata_i[smd_pkg::COUNT_W-1:0];
      end
    end
  end

  // Sample buffer: written on each accepted word that no image count write meets, read during the second pass.
  always_ff @(posedge clk_i) begin
    if (accept && !(cfg_write && cfg_hit)) begin
      sample_buffer[wr_addr] <= sample;
    end
    rd_data_q <= sample_buffer[rd_addr];
  end

  // Deviation pipeline and result registers.
  always_ff @(posedge clk_i) begin
    dev_q    <= (rd_data_q >= mean_q) ? (rd_data_q - mean_q) : (mean_q - rd_data_q);
    sq_q     <= dev_q * dev_q;
    acc_q    <= acc_d;
    mean_q   <= mean_d;
    devout_q <= devout_d;
  end

  assign result_valid_o        = valid_q;
  assign avg_amplitude_o       = mean_q;
  assign amplitude_deviation_o = devout_q;

  // A result comes only at the end of a computation, and the block is ready
  // for the next pixel in the same cycle.
  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o && $past(state_q == smd_pkg::ST_SQRT_WAIT))
    else $error("result strobe outside the end of a computation");

  // The sequencer never starts the shared unit while it is still iterating.
  a_unit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_req.start |-> !arith_rsp.busy)
    else $error("shared unit started while busy");

  // While samples are being taken, the count stays below the samples per pixel.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smd_pkg::ST_LOAD) |-> (count_q < n_eff))
    else $error("sample count reached the image count while loading");

  // The unit only reports completion while a computation waits for it.
  a_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_rsp.done |-> (state_q == smd_pkg::ST_MEAN_WAIT ||
                        state_q == smd_pkg::ST_MSD_WAIT ||
                        state_q == smd_pkg::ST_SQRT_WAIT))
    else $error("shared unit finished with no computation waiting");

endmodule

// ===== rtl/smd_arith.sv =====
// Shared iterative unit: restoring division by a small count, or a floor
// square root, one digit per cycle through one compare and subtract stage.
module smd_arith (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smd_pkg::arith_req_t           req_i,
  input  logic [smd_pkg::ACC_W-1:0]     operand_i,
  input  logic [smd_pkg::COUNT_W-1:0]   divisor_i,
  output smd_pkg::arith_rsp_t           rsp_o,
  output logic [smd_pkg::ACC_W-1:0]     result_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [smd_pkg::STEP_W-1:0]    cnt_q, cnt_d;
  smd_pkg::arith_op_e            op_q, op_d;
  logic [smd_pkg::ACC_W-1:0]     work_q, work_d;
  logic [smd_pkg::CMP_W-1:0]     rem_q, rem_d;
  logic [smd_pkg::ACC_W-1:0]     res_q, res_d;
  logic [smd_pkg::COUNT_W-1:0]   div_q, div_d;

  logic [smd_pkg::CMP_W-1:0]     cmp_a, cmp_b, cmp_diff;
  logic                          cmp_ge;

  // The one compare and subtract stage that both operations share.
  always_comb begin
    case (op_q)
      smd_pkg::OP_DIV: begin
        cmp_a = {rem_q[smd_pkg::CMP_W-2:0], work_q[smd_pkg::ACC_W-1]};
        cmp_b = smd_pkg::CMP_W'(div_q);
      end
      smd_pkg::OP_SQRT: begin
        cmp_a = {rem_q[smd_pkg::CMP_W-3:0], work_q[smd_pkg::ACC_W-1:smd_pkg::ACC_W-2]};
        cmp_b = {res_q[smd_pkg::CMP_W-3:0], 2'b01};
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
    cmp_ge   = (cmp_a >= cmp_b);
    cmp_diff = cmp_a - cmp_b;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    work_d = work_q;
    rem_d  = rem_q;
    res_d  = res_q;
    div_d  = div_q;
    if (busy_q) begin
      rem_d = cmp_ge ? cmp_diff : cmp_a;
      res_d = {res_q[smd_pkg::ACC_W-2:0], cmp_ge};
      if (op_q == smd_pkg::OP_DIV) begin
        work_d = {work_q[smd_pkg::ACC_W-2:0], 1'b0};
      end else begin
        work_d = {work_q[smd_pkg::ACC_W-3:0], 2'b00};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      rem_d  = '0;
      res_d  = '0;
      div_d  = divisor_i;
      if (req_i.op == smd_pkg::OP_DIV) begin
        work_d = operand_i;
        cnt_d  = smd_pkg::STEP_W'(smd_pkg::DIV_STEPS - 1);
      end else begin
        // The radicand sits at the top of the shift register.
        work_d = {operand_i[smd_pkg::SQ_W-1:0], (smd_pkg::ACC_W - smd_pkg::SQ_W)'(0)};
        cnt_d  = smd_pkg::STEP_W'(smd_pkg::ROOT_STEPS - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= smd_pkg::OP_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    div_q  <= div_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign result_o   = res_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Checks the per-pixel mean and deviation unit against a predictor written from
// scratch. Samples go in on the start/busy handshake, the image count goes in
// over the APB-style port, and every strobed result is compared with the oldest
// pixel the predictor has completed.
module tb_top;
  import smd_pkg::*;

  localparam int unsigned MAX_IMAGES = 64;
  localparam int unsigned CLK_PERIOD = 4;
  localparam int unsigned RESET_CYCLES = 11;
  // Long enough to cover the time a pixel of the largest stack keeps the
  // block busy after its last word, with room to spare.
  localparam int unsigned QUIET_CYCLES = 2 * MAX_IMAGES + 120;
  localparam int unsigned PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 175;
  localparam logic [ADDR_W-1:0] IMAGE_COUNT_ADDR = ADDR_W'(4 * REG_IMAGE_COUNT);

  // Mean and deviation of one pixel, the two fields of one result.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] deviation;
  } pixel_stats_t;

  // Keeps its own copy of the image count and of the pixel being collected,
  // and queues the statistics of every pixel that a word completes.
  class pixel_stats_predictor;
    logic [SAMPLE_W-1:0] samples [MAX_IMAGES];
    logic [COUNT_W-1:0]  image_count;
    int unsigned         sample_count;
    longint unsigned     running_sum;
    pixel_stats_t        expected_stats [$];
    int unsigned         errors;

    function new();
      image_count  = 1;
      sample_count = 0;
      running_sum  = 0;
      errors       = 0;
    endfunction

    // A register write also throws away a partly collected pixel.
    function void set_image_count(input logic [COUNT_W-1:0] value);
      image_count  = value;
      sample_count = 0;
      running_sum  = 0;
    endfunction

    function int unsigned images_per_pixel();
      if (image_count == 0) return 1;
      if (image_count > MAX_IMAGES) return MAX_IMAGES;
      return image_count;
    endfunction

    // Largest r with r * r <= v, built one bit at a time from the top.
    function logic [SAMPLE_W-1:0] floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = SAMPLE_W; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root[SAMPLE_W-1:0];
    endfunction

    function void take_sample(input logic [SAMPLE_W-1:0] amplitude);
      int unsigned     n;
      longint unsigned mean;
      longint unsigned square_sum;
      longint unsigned spread;
      pixel_stats_t    stats;
      n = images_per_pixel();
      if (sample_count >= n) begin
        sample_count = 0;
        running_sum  = 0;
      end
      samples[sample_count] = amplitude;
      running_sum += amplitude;
      sample_count++;
      if (sample_count < n) return;
      mean = running_sum / n;
      // The exact sum of squares fits easily in 64 bits, so it is divided by n
      // once at the end, as the block also does.
      square_sum = 0;
      for (int k = 0; k < n; k++) begin
        spread = (samples[k] >= mean) ? samples[k] - mean : mean - samples[k];
        square_sum += spread * spread;
      end
      stats.mean      = mean[SAMPLE_W-1:0];
      stats.deviation = floor_root(square_sum / n);
      expected_stats = {expected_stats, stats};
      sample_count = 0;
      running_sum  = 0;
    endfunction

    function void check_stats(input logic [SAMPLE_W-1:0] mean,
                              input logic [SAMPLE_W-1:0] deviation);
      pixel_stats_t want;
      if (expected_stats.size() == 0) begin
        $error("unexpected result: avg_amplitude %0d amplitude_deviation %0d",
               mean, deviation);
        errors++;
        return;
      end
      want = expected_stats.pop_front();
      if (mean !== want.mean) begin
        $error("avg_amplitude: expected %0d, actual %0d", want.mean, mean);
        errors++;
      end
      if (deviation !== want.deviation) begin
        $error("amplitude_deviation: expected %0d, actual %0d", want.deviation, deviation);
        errors++;
      end
    endfunction
  endclass

  // Every input has a known value from time zero on.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic [SAMPLE_W-1:0] amplitude_i = '0;
  logic                psel_i      = 1'b0;
  logic                penable_i   = 1'b0;
  logic                pwrite_i    = 1'b0;
  logic [ADDR_W-1:0]   paddr_i     = '0;
  logic [DATA_W-1:0]   pwdata_i    = '0;

  logic                busy_o;
  logic                result_valid_o;
  logic [SAMPLE_W-1:0] avg_amplitude_o;
  logic [SAMPLE_W-1:0] amplitude_deviation_o;
  logic [DATA_W-1:0]   prdata_o;
  logic                pready_o;

  pixel_stats_predictor predictor;
  int unsigned          readback_errors = 0;

  stack_mean_and_deviation #(
    .MAX_IMAGES     (MAX_IMAGES),
    .AMPLITUDE_BITS (SAMPLE_W)
  ) u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy_o                (busy_o),
    .amplitude_i           (amplitude_i),
    .result_valid_o        (result_valid_o),
    .avg_amplitude_o       (avg_amplitude_o),
    .amplitude_deviation_o (amplitude_deviation_o),
    .psel_i                (psel_i),
    .penable_i             (penable_i),
    .pwrite_i              (pwrite_i),
    .paddr_i               (paddr_i),
    .pwdata_i              (pwdata_i),
    .prdata_o              (prdata_o),
    .pready_o              (pready_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // A result is only on the ports for one cycle and cannot be held off, so it
  // is compared at the rising edge that closes that cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      predictor.check_stats(avg_amplitude_o, amplitude_deviation_o);
    end
  end

  // Offers one word from the next falling edge and holds it until the block
  // takes it. start_i stays high, so a word that follows at once goes in on the
  // very next cycle if busy_o is low; hold_off and drain_results lower it first.
  task automatic drive_sample(input logic [SAMPLE_W-1:0] amplitude);
    @(negedge clk_i);
    start_i     = 1'b1;
    amplitude_i = amplitude;
    do @(posedge clk_i); while (busy_o);
    predictor.take_sample(amplitude);
  endtask

  // Idles the sample side: start_i goes low and the data lines carry noise
  // that the block must ignore while start_i is low.
  task automatic hold_off();
    @(negedge clk_i);
    start_i     = 1'b0;
    amplitude_i = SAMPLE_W'($urandom());
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (predictor.expected_stats.size() != 0) @(posedge clk_i);
  endtask

  // A word that completes no pixel gives nothing to wait for, so after the last
  // expected result the block gets its full latency before it counts as idle.
  task automatic settle();
    drain_results();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Writes the image count, then reads it straight back in a second transfer.
  // The bits above the register carry noise that the block must drop.
  task automatic write_image_count(input logic [COUNT_W-1:0] value);
    logic [DATA_W-1:0] readback;
    @(negedge clk_i);
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = 1'b1;
    paddr_i   = IMAGE_COUNT_ADDR;
    pwdata_i  = $urandom();
    pwdata_i[COUNT_W-1:0] = value;
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    predictor.set_image_count(value);
    @(negedge clk_i);
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
    pwdata_i  = '0;
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    readback = prdata_o;
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
    if (readback !== DATA_W'(value)) begin
      $error("image_count readback: expected %0d, actual %0d", value, readback);
      readback_errors++;
    end
  endtask

  initial begin
    logic [COUNT_W-1:0]  count;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] amplitude;
    int unsigned         idle_pct;

    predictor = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The count is still one after reset, so every word is a
    // pixel of its own, and the extremes come out as their own mean.
    drive_sample('0);
    drive_sample('1);
    drive_sample(16'h8000);
    drive_sample(16'h0001);

    // A count of zero behaves as a count of one.
    settle();
    write_image_count('0);
    drive_sample(16'h5A5A);

    // The widest spread two samples can have.
    settle();
    write_image_count(2);
    drive_sample('0);
    drive_sample('1);

    // A mean that has to be rounded down, then a pixel left half done.
    settle();
    write_image_count(3);
    drive_sample(16'h0000);
    drive_sample(16'h0001);
    drive_sample(16'h0001);
    drive_sample('1);
    drive_sample(16'h1234);

    // Writing the count drops those two words; this pixel starts from scratch.
    settle();
    write_image_count(4);
    drive_sample('1);
    drive_sample('0);
    drive_sample('1);
    drive_sample('0);

    // Identical samples have no deviation at all.
    settle();
    write_image_count(5);
    repeat (5) drive_sample(16'h1234);

    // Random part. Each phase sets its own count, from zero up to values that
    // saturate at the buffer depth, and its own sender idling. The receiver
    // phase has no idling of its own here since results cannot be held off.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       count = 1;
        1:       count = 2;
        2:       count = COUNT_W'(MAX_IMAGES);
        3:       count = '1;
        4:       count = '0;
        5:       count = COUNT_W'($urandom_range(3, 12));
        6:       count = COUNT_W'($urandom_range(MAX_IMAGES + 1, (1 << COUNT_W) - 2));
        default: count = COUNT_W'($urandom_range(1, MAX_IMAGES));
      endcase
      write_image_count(count);
      case (phase % 4)
        1:       idle_pct = 69;
        3:       idle_pct = 9;
        default: idle_pct = 0;
      endcase
      base = SAMPLE_W'($urandom());
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // Now and then the sender waits until every pending pixel is out.
        if ($urandom_range(0, 39) == 0) drain_results();
        while ($urandom_range(0, 99) < idle_pct) hold_off();
        // Mix full-range noise, the two rails, a tight cluster around a phase
        // base and small values, so deviations run from zero to the maximum.
        case ($urandom_range(0, 3))
          0:       amplitude = SAMPLE_W'($urandom());
          1:       amplitude = $urandom_range(0, 1) ? '1 : '0;
          2:       amplitude = base + SAMPLE_W'($urandom_range(0, 15)) - SAMPLE_W'(8);
          default: amplitude = SAMPLE_W'($urandom_range(0, 255));
        endcase
        drive_sample(amplitude);
      end
    end

    settle();
    if (predictor.errors == 0 && readback_errors == 0 &&
        predictor.expected_stats.size() == 0) begin
      $display("PASS stack_mean_and_deviation");
    end else begin
      $display("FAIL stack_mean_and_deviation");
    end
    $finish;
  end

  // Several times the slowest correct run: every word a pixel of its own with
  // sender gaps on top, plus the quiet time around each count change.
  initial begin
    #4_000_000;
    $display("FAIL stack_mean_and_deviation");
    $finish;
  end

endmodule
